[hdl/c8_pkg.sv]
// Shared types, codes and constants of the CHIP-8 instruction executor.
package c8_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 32;
  localparam int STACK_DEPTH    = 16;
  localparam int ADDR_W         = 12;

  localparam logic [4:0] NO_KEY = 5'd16;
  localparam logic [3:0] REG_F  = 4'hF;

  // transaction opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_ROW  = 2'd2;

  // instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEQK = 4'h3;
  localparam logic [3:0] GRP_SNEK = 4'h4;
  localparam logic [3:0] GRP_SEQV = 4'h5;
  localparam logic [3:0] GRP_LDK  = 4'h6;
  localparam logic [3:0] GRP_ADDK = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNEV = 4'h9;
  localparam logic [3:0] GRP_SETI = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRAW = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  // ALU forms
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // low-byte forms
  localparam logic [7:0] KK_CLS  = 8'hE0;
  localparam logic [7:0] KK_RET  = 8'hEE;
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_LDDT = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [15:0] keys_down;
    logic [4:0]  key_event;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } in_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic        error_flag;
    logic        key_wait;
    logic [7:0]  sound_level;
    logic [63:0] display_row;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic       we;
    logic [3:0] addr;
    logic [7:0] data;
  } rf_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_RREAD, S_EXEC, S_WB2,
    S_DRED, S_DRD, S_DDAT, S_BCD, S_STR_RD, S_STR_WR,
    S_LDR_RD, S_LDR_WR, S_ROW_RD, S_ROW_DAT, S_DONE
  } state_t;

endpackage

[hdl/chip8_instruction_executor.sv]
// Top level of the CHIP-8 instruction executor: sequencer and architectural registers.
//
// Usage:
//  - Input channel in_valid / in_stall / in_data carries one transaction: load a
//    memory byte, execute the instruction at the program counter, or read a
//    framebuffer row. Result channel out_valid / out_stall / out_data returns one
//    result per transaction (program counter, error flag, key wait, sound level,
//    display row).
//  - ALU forms that also set VF add a second write-back step; Dxyn first reduces
//    its coordinates, then reads and draws each sprite byte; Fx33 writes three
//    digits; Fx55/Fx65 step through V0..Vx one register at a time. The sequencer
//    handles one transaction at a time, stepping through the main memory and
//    register file, and takes no new one until the current one leaves completion.
//  - A new transaction is taken while a finished result still sits in the output
//    register; only the completion step waits on a full output register.
//  - Reset (rst_n low, synchronous) clears the registers and starts a sweep that
//    zeroes all of main memory; in_stall stays high until it ends.
//    Register file and framebuffer clear at once through valid bits.
//  - While out_stall is high the result holds in out_data, and a sequencer that
//    reaches its completion step parks there.
module chip8_instruction_executor #(
  parameter int DISPLAY_WIDTH  = c8_pkg::DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = c8_pkg::DISPLAY_HEIGHT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  c8_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output c8_pkg::out_t  out_data
);
  import c8_pkg::*;

  localparam int RW   = $clog2(DISPLAY_HEIGHT);
  localparam int CW   = $clog2(DISPLAY_WIDTH);
  localparam int PadW = 64 - DISPLAY_WIDTH;
  localparam logic [7:0] W8 = 8'(DISPLAY_WIDTH);
  localparam logic [7:0] H8 = 8'(DISPLAY_HEIGHT);

  state_t      state_r, state_nxt;
  in_t         in_r;
  logic [15:0] ins_r;
  logic [7:0]  vx_r, vy_r;
  logic [11:0] pc_r;
  logic [15:0] i_r;
  logic [3:0]  sp_r;
  logic [11:0] stack_r [STACK_DEPTH];
  logic [7:0]  dt_r, st_r;
  logic [4:0]  pkey_r;
  logic        err_r, wait_r;
  logic [3:0]  cnt_r;
  logic [7:0]  col_r, row_r;
  rf_wr_t      wb_r;
  logic [63:0] row_out_r;
  logic        out_valid_r;
  out_t        out_r;

  // memory side
  mem_wr_t     mem_wr;
  logic [11:0] mem_raddr;
  logic [7:0]  mem_q;
  logic        mem_busy;
  rf_wr_t      rf_wr;
  logic [3:0]  rf_ra, rf_rb;
  logic [7:0]  rf_qa, rf_qb;
  logic                     fb_clear, fb_we;
  logic [RW-1:0]            fb_waddr, fb_raddr;
  logic [DISPLAY_WIDTH-1:0] fb_wdata, fb_q, mask;

  // decode
  logic [3:0]  grp, xr, nib;
  logic [7:0]  kk;
  logic [11:0] nnn, pc_inc, pc_skip, pc_exec, addr_i;
  logic        key_held, in_acc, out_load, row_ok;
  logic [8:0]  sum9;
  rf_wr_t      exec_wb;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem8;
  logic [6:0]  bcd_rem, bcd_o;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_digit;

  assign grp      = ins_r[15:12];
  assign xr       = ins_r[11:8];
  assign kk       = ins_r[7:0];
  assign nib      = ins_r[3:0];
  assign nnn      = ins_r[11:0];
  assign pc_inc   = pc_r + 12'd2;
  assign pc_skip  = pc_r + 12'd4;
  assign key_held = in_r.keys_down[vx_r[3:0]];
  assign sum9     = {1'b0, vx_r} + {1'b0, vy_r};
  assign addr_i   = i_r[11:0] + {8'd0, cnt_r};
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign row_ok   = 7'(in_r.row_select) < 7'(DISPLAY_HEIGHT);
  assign in_stall = !((state_r == S_IDLE) && !mem_busy);

  // decimal digits of Vx: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    if (vx_r >= 8'd200) begin
      bcd_h = 2'd2; bcd_rem8 = vx_r - 8'd200;
    end else if (vx_r >= 8'd100) begin
      bcd_h = 2'd1; bcd_rem8 = vx_r - 8'd100;
    end else begin
      bcd_h = 2'd0; bcd_rem8 = vx_r;
    end
    bcd_rem  = bcd_rem8[6:0];
    bcd_prod = {8'd0, bcd_rem} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem - ({3'd0, bcd_t} * 7'd10);
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h};
      2'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = {1'b0, bcd_o};
    endcase
  end

  // sprite byte to row mask, columns wrapped
  always_comb begin
    logic [8:0]    c;
    logic [CW-1:0] idx;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, col_r} + 9'(i);
      if (c >= {1'b0, W8}) c = c - {1'b0, W8};
      idx = CW'(DISPLAY_WIDTH - 1) - c[CW-1:0];
      if (mem_q[7-i]) mask[idx] = 1'b1;
    end
  end

  // program counter after execute
  always_comb begin
    pc_exec = pc_inc;
    unique case (grp)
      GRP_SYS:  if (kk == KK_RET) pc_exec = stack_r[sp_r];
      GRP_JP, GRP_CALL: pc_exec = nnn;
      GRP_SEQK: if (vx_r == kk) pc_exec = pc_skip;
      GRP_SNEK: if (vx_r != kk) pc_exec = pc_skip;
      GRP_SEQV: if (vx_r == vy_r) pc_exec = pc_skip;
      GRP_SNEV: if (vx_r != vy_r) pc_exec = pc_skip;
      GRP_JPV0: pc_exec = nnn + {4'd0, vy_r};
      GRP_KEY: begin
        if (kk == KK_SKP && key_held) pc_exec = pc_skip;
        if (kk == KK_SKNP && !key_held) pc_exec = pc_skip;
      end
      GRP_MISC: if (kk == KK_WKEY && pkey_r >= NO_KEY) pc_exec = pc_r;
      default: pc_exec = pc_inc;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        unique case (in_data.opcode)
          OP_EXEC: state_nxt = S_F0;
          OP_ROW:  state_nxt = S_ROW_RD;
          default: state_nxt = S_DONE;
        endcase
      end
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_RREAD;
      S_RREAD: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_DONE;
        if (grp == GRP_ALU) begin
          case (nib) inside
            ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL: state_nxt = S_WB2;
            default: state_nxt = S_DONE;
          endcase
        end else if (grp == GRP_DRAW) begin
          state_nxt = S_DRED;
        end else if (grp == GRP_MISC) begin
          if (kk == KK_BCD) state_nxt = S_BCD;
          else if (kk == KK_STR) state_nxt = S_STR_RD;
          else if (kk == KK_LDR) state_nxt = S_LDR_RD;
        end
      end
      S_WB2:   state_nxt = S_DONE;
      S_DRED:  if (col_r < W8 && row_r < H8) state_nxt = (nib == 4'd0) ? S_DONE : S_DRD;
      S_DRD:   state_nxt = S_DDAT;
      S_DDAT:  state_nxt = (cnt_r + 4'd1 == nib) ? S_DONE : S_DRD;
      S_BCD:   if (cnt_r == 4'd2) state_nxt = S_DONE;
      S_STR_RD: state_nxt = S_STR_WR;
      S_STR_WR: state_nxt = (cnt_r == xr) ? S_DONE : S_STR_RD;
      S_LDR_RD: state_nxt = S_LDR_WR;
      S_LDR_WR: state_nxt = (cnt_r == xr) ? S_DONE : S_LDR_RD;
      S_ROW_RD: state_nxt = S_ROW_DAT;
      S_ROW_DAT: state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory and register-file requests
  always_comb begin
    mem_wr    = '0;
    mem_raddr = pc_r;
    rf_wr     = '0;
    rf_ra     = xr;
    rf_rb     = 4'd0;
    exec_wb   = '0;
    fb_clear  = 1'b0;
    fb_we     = 1'b0;
    fb_waddr  = row_r[RW-1:0];
    fb_wdata  = fb_q ^ mask;
    fb_raddr  = row_r[RW-1:0];
    unique case (state_r)
      S_IDLE: mem_wr = '{we: in_acc && (in_data.opcode == OP_LOAD),
                         addr: in_data.load_address, data: in_data.load_byte};
      S_F1:   mem_raddr = pc_r + 12'd1;
      S_F2: begin
        rf_ra = xr;
        rf_rb = (grp == GRP_JPV0) ? 4'd0 : mem_q[7:4];
      end
      S_EXEC: begin
        exec_wb.we = 1'b1;
        unique case (grp)
          GRP_SYS:  fb_clear = (kk == KK_CLS);
          GRP_LDK:  rf_wr = '{1'b1, xr, kk};
          GRP_ADDK: rf_wr = '{1'b1, xr, vx_r + kk};
          GRP_RND:  rf_wr = '{1'b1, xr, in_r.random_byte & kk};
          GRP_DRAW: rf_wr = '{1'b1, REG_F, 8'd0};
          GRP_ALU: begin
            case (nib)
              ALU_MOV: rf_wr = '{1'b1, xr, vy_r};
              ALU_OR:  rf_wr = '{1'b1, xr, vx_r | vy_r};
              ALU_AND: rf_wr = '{1'b1, xr, vx_r & vy_r};
              ALU_XOR: rf_wr = '{1'b1, xr, vx_r ^ vy_r};
              ALU_ADD: begin
                rf_wr   = '{1'b1, xr, sum9[7:0]};
                exec_wb = '{1'b1, REG_F, {7'd0, sum9[8]}};
              end
              ALU_SUB: begin
                rf_wr   = '{1'b1, xr, vx_r - vy_r};
                exec_wb = '{1'b1, REG_F, {7'd0, vx_r > vy_r}};
              end
              ALU_SBN: begin
                rf_wr   = '{1'b1, xr, vy_r - vx_r};
                exec_wb = '{1'b1, REG_F, {7'd0, vy_r > vx_r}};
              end
              ALU_SHR: begin
                rf_wr   = '{1'b1, REG_F, {7'd0, vx_r[0]}};
                exec_wb = '{1'b1, xr, {1'b0, vx_r[7:1]}};
              end
              ALU_SHL: begin
                rf_wr   = '{1'b1, REG_F, {7'd0, vx_r[7]}};
                exec_wb = '{1'b1, xr, {vx_r[6:0], 1'b0}};
              end
              default: rf_wr = '0;
            endcase
          end
          GRP_MISC: begin
            if (kk == KK_LDDT) rf_wr = '{1'b1, xr, dt_r};
            if (kk == KK_WKEY && pkey_r < NO_KEY) rf_wr = '{1'b1, xr, {4'd0, pkey_r[3:0]}};
          end
          default: rf_wr = '0;
        endcase
      end
      S_WB2:    rf_wr = wb_r;
      S_DRD:    mem_raddr = addr_i;
      S_DDAT: begin
        fb_we = 1'b1;
        rf_wr = '{|(fb_q & mask), REG_F, 8'd1};
      end
      S_BCD:    mem_wr = '{1'b1, addr_i, bcd_digit};
      S_STR_RD: rf_ra = cnt_r;
      S_STR_WR: mem_wr = '{1'b1, addr_i, rf_qa};
      S_LDR_RD: mem_raddr = addr_i;
      S_LDR_WR: rf_wr = '{1'b1, cnt_r, mem_q};
      S_ROW_RD: fb_raddr = RW'(in_r.row_select);
      default:  mem_wr = '0;
    endcase
  end

  // architectural and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      i_r         <= '0;
      sp_r        <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) stack_r[k] <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      pkey_r      <= NO_KEY;
      err_r       <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_data.key_event < NO_KEY) pkey_r <= in_data.key_event;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == S_EXEC) begin
        pc_r <= pc_exec;
        case (grp)
          GRP_SYS: begin
            if (kk == KK_RET) sp_r <= sp_r - 4'd1;
            else if (kk != KK_CLS) err_r <= 1'b1;
          end
          GRP_CALL: begin
            sp_r <= sp_r + 4'd1;
            stack_r[sp_r + 4'd1] <= pc_inc;
          end
          GRP_ALU: begin
            case (nib) inside
              ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN,
              ALU_SHL: err_r <= err_r;
              default: err_r <= 1'b1;
            endcase
          end
          GRP_SETI: i_r <= {4'd0, nnn};
          GRP_KEY:  if (kk != KK_SKP && kk != KK_SKNP) err_r <= 1'b1;
          GRP_MISC: begin
            case (kk)
              KK_WKEY: begin
                if (pkey_r >= NO_KEY) wait_r <= 1'b1;
                else begin
                  pkey_r <= NO_KEY;
                  wait_r <= 1'b0;
                end
              end
              KK_SDT:  dt_r <= vx_r;
              KK_SST:  st_r <= vx_r;
              KK_ADDI: i_r  <= i_r + {8'd0, vx_r};
              KK_FONT: i_r  <= {8'd0, vx_r} * 16'd5;
              default: i_r  <= i_r;
            endcase
          end
          default: pc_r <= pc_exec;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r      <= in_data;
      row_out_r <= '0;
    end
    case (state_r)
      S_F1:    ins_r[15:8] <= mem_q;
      S_F2:    ins_r[7:0]  <= mem_q;
      S_RREAD: begin
        vx_r <= rf_qa;
        vy_r <= rf_qb;
      end
      S_EXEC: begin
        wb_r  <= exec_wb;
        col_r <= vx_r;
        row_r <= vy_r;
        cnt_r <= 4'd0;
      end
      S_DRED: begin
        if (col_r >= W8) col_r <= col_r - W8;
        if (row_r >= H8) row_r <= row_r - H8;
      end
      S_DDAT: begin
        cnt_r <= cnt_r + 4'd1;
        row_r <= (row_r + 8'd1 == H8) ? 8'd0 : row_r + 8'd1;
      end
      S_BCD, S_STR_WR, S_LDR_WR: cnt_r <= cnt_r + 4'd1;
      S_ROW_DAT: if (row_ok) row_out_r <= 64'(fb_q) << PadW;
      default: cnt_r <= cnt_r;
    endcase
    if (out_load) begin
      out_r <= '{program_counter: pc_r, error_flag: err_r, key_wait: wait_r,
                 sound_level: st_r, display_row: row_out_r};
    end
  end

  c8_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_q),
    .busy  (mem_busy)
  );

  c8_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rf_wr),
    .ra    (rf_ra),
    .rb    (rf_rb),
    .qa    (rf_qa),
    .qb    (rf_qb)
  );

  c8_frame #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (fb_clear),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_done_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_stall) |=> out_valid_r)
    else $error("completion did not present a result");
  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $past(state_r) == S_RREAD)
    else $error("execute without register read");
  a_load_completes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode == OP_LOAD) |=> state_r == S_DONE)
    else $error("load transaction did not complete");
`endif

endmodule

[hdl/c8_mem.sv]
// Main byte memory with a clearing sweep after reset.
module c8_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c8_pkg::mem_wr_t           wr,
  input  logic [c8_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                rdata,
  output logic                      busy
);
  import c8_pkg::*;

  logic [7:0]        mem [MEM_BYTES];
  logic [ADDR_W-1:0] clr_addr_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) mem[clr_addr_r] <= 8'd0;
    else if (wr.we) mem[wr.addr] <= wr.data;
    rdata <= mem[raddr];
  end

  assign busy = busy_r;

endmodule

[hdl/c8_regs.sv]
// General register file V0..VF: two read ports, one write port.
module c8_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  c8_pkg::rf_wr_t        wr,
  input  logic [3:0]            ra,
  input  logic [3:0]            rb,
  output logic [7:0]            qa,
  output logic [7:0]            qb
);
  import c8_pkg::*;

  logic [7:0]  mem [16];
  logic [15:0] valid_r;
  logic [7:0]  qa_r, qb_r;
  logic        va_r, vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (wr.we) valid_r[wr.addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    qa_r <= mem[ra];
    qb_r <= mem[rb];
    va_r <= valid_r[ra];
    vb_r <= valid_r[rb];
  end

  // unwritten registers read as zero
  assign qa = va_r ? qa_r : 8'd0;
  assign qb = vb_r ? qb_r : 8'd0;

endmodule

[hdl/c8_frame.sv]
// Framebuffer rows with per-row valid bits, so a clear resets all rows at once.
module c8_frame #(
  parameter int DISPLAY_WIDTH  = c8_pkg::DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = c8_pkg::DISPLAY_HEIGHT,
  localparam int RW = $clog2(DISPLAY_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     we,
  input  logic [RW-1:0]            waddr,
  input  logic [DISPLAY_WIDTH-1:0] wdata,
  input  logic [RW-1:0]            raddr,
  output logic [DISPLAY_WIDTH-1:0] rdata
);
  import c8_pkg::*;

  logic [DISPLAY_WIDTH-1:0]  mem [DISPLAY_HEIGHT];
  logic [DISPLAY_HEIGHT-1:0] valid_r;
  logic [DISPLAY_WIDTH-1:0]  q_r;
  logic                      v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (clear) valid_r <= '0;
    else if (we) valid_r[waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    q_r <= mem[raddr];
    v_r <= valid_r[raddr];
  end

  assign rdata = v_r ? q_r : '0;

endmodule

[tb/sv/tb.sv]
// Testbench for the CHIP-8 instruction executor: directed and random programs checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import c8_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_t out_data;

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chip8_instruction_executor i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state: a private copy of every architectural store
  logic [7:0]  mem_img [MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [15:0] idx_reg;
  logic [11:0] pc_reg;
  logic [3:0]  sp_reg;
  logic [11:0] ret_stack [STACK_DEPTH];
  logic [63:0] frame [DISPLAY_HEIGHT];
  logic [7:0]  delay_reg, sound_reg;
  logic [4:0]  key_latch;
  logic        err_sticky, key_waiting;

  out_t result_queue [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;     // set by a test to force a long receiver stall
  int   hold_cycles = 0;

  // Clear all predictor state to its power-up values
  task automatic clear_model();
    foreach (mem_img[i]) mem_img[i] = '0;
    foreach (vreg[i]) vreg[i] = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    foreach (frame[i]) frame[i] = '0;
    idx_reg = '0; pc_reg = '0; sp_reg = '0;
    delay_reg = '0; sound_reg = '0;
    key_latch = NO_KEY; err_sticky = 1'b0; key_waiting = 1'b0;
  endtask

  // Draw a sprite at (xs, ys): XOR with wrap, VF marks any collision
  function automatic void draw_sprite(input logic [7:0] xs, input logic [7:0] ys,
                                      input logic [3:0] n);
    logic [7:0] bits;
    int row, col;
    vreg[REG_F] = 8'd0;
    for (int j = 0; j < n; j++) begin
      bits = mem_img[12'(idx_reg + 16'(j))];
      row = (int'(ys) + j) % DISPLAY_HEIGHT;
      for (int i = 0; i < 8; i++) begin
        if (bits[7-i]) begin
          col = (int'(xs) + i) % DISPLAY_WIDTH;
          if (frame[row][63-col]) vreg[REG_F] = 8'd1;
          frame[row][63-col] = ~frame[row][63-col];
        end
      end
    end
  endfunction

  // Run one instruction at the program counter
  function automatic void run_instruction(input logic [15:0] keys, input logic [7:0] rnd);
    logic [15:0] ins;
    logic [3:0]  x, y, nib;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn, nxt;
    logic [8:0]  sum;
    logic        held;
    ins = {mem_img[pc_reg], mem_img[pc_reg + 12'd1]};
    x = ins[11:8]; y = ins[7:4]; nib = ins[3:0]; kk = ins[7:0]; nnn = ins[11:0];
    vx = vreg[x]; vy = vreg[y];
    nxt = pc_reg + 12'd2;
    case (ins[15:12])
      GRP_SYS: begin
        if (kk == KK_CLS) foreach (frame[i]) frame[i] = '0;
        else if (kk == KK_RET) begin
          nxt = ret_stack[sp_reg];
          sp_reg = sp_reg - 4'd1;
        end else err_sticky = 1'b1;
      end
      GRP_JP: nxt = nnn;
      GRP_CALL: begin
        sp_reg = sp_reg + 4'd1;
        ret_stack[sp_reg] = nxt;
        nxt = nnn;
      end
      GRP_SEQK: if (vx == kk) nxt += 12'd2;
      GRP_SNEK: if (vx != kk) nxt += 12'd2;
      GRP_SEQV: if (vx == vy) nxt += 12'd2;
      GRP_LDK:  vreg[x] = kk;
      GRP_ADDK: vreg[x] = vx + kk;
      GRP_ALU: begin
        case (nib)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vreg[x] = sum[7:0]; vreg[REG_F] = {7'd0, sum[8]};
          end
          ALU_SUB: begin vreg[x] = vx - vy; vreg[REG_F] = {7'd0, vx > vy}; end
          ALU_SHR: begin vreg[REG_F] = {7'd0, vx[0]}; vreg[x] = vx >> 1; end
          ALU_SBN: begin vreg[x] = vy - vx; vreg[REG_F] = {7'd0, vy > vx}; end
          ALU_SHL: begin vreg[REG_F] = {7'd0, vx[7]}; vreg[x] = vx << 1; end
          default: err_sticky = 1'b1;
        endcase
      end
      GRP_SNEV: if (vx != vy) nxt += 12'd2;
      GRP_SETI: idx_reg = {4'd0, nnn};
      GRP_JPV0: nxt = nnn + {4'd0, vreg[0]};
      GRP_RND:  vreg[x] = rnd & kk;
      GRP_DRAW: draw_sprite(vx, vy, nib);
      GRP_KEY: begin
        held = keys[vx[3:0]];
        if (kk == KK_SKP) begin if (held) nxt += 12'd2; end
        else if (kk == KK_SKNP) begin if (!held) nxt += 12'd2; end
        else err_sticky = 1'b1;
      end
      default: begin
        case (kk)
          KK_LDDT: vreg[x] = delay_reg;
          KK_WKEY: begin
            if (key_latch >= NO_KEY) begin key_waiting = 1'b1; nxt = pc_reg; end
            else begin
              vreg[x] = {3'd0, key_latch};
              key_latch = NO_KEY; key_waiting = 1'b0;
            end
          end
          KK_SDT:  delay_reg = vx;
          KK_SST:  sound_reg = vx;
          KK_ADDI: idx_reg = idx_reg + {8'd0, vx};
          KK_FONT: idx_reg = 16'(vx) * 16'd5;
          KK_BCD: begin
            mem_img[idx_reg[11:0]] = vx / 100;
            mem_img[12'(idx_reg + 16'd1)] = (vx / 10) % 10;
            mem_img[12'(idx_reg + 16'd2)] = vx % 10;
          end
          KK_STR: for (int i = 0; i <= x; i++) mem_img[12'(idx_reg + 16'(i))] = vreg[i];
          KK_LDR: for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(idx_reg + 16'(i))];
          default: ;
        endcase
      end
    endcase
    pc_reg = nxt;
  endfunction

  // Compute the expected result of one transaction and update the predictor
  function automatic out_t predict_result(input in_t t);
    out_t r;
    r.display_row = '0;
    if (t.key_event < NO_KEY) key_latch = t.key_event;
    case (t.opcode)
      OP_LOAD: mem_img[t.load_address] = t.load_byte;
      OP_EXEC: run_instruction(t.keys_down, t.random_byte);
      OP_ROW:  if (t.row_select < DISPLAY_HEIGHT) r.display_row = frame[t.row_select];
      default: ;
    endcase
    r.program_counter = pc_reg;
    r.error_flag = err_sticky;
    r.key_wait = key_waiting;
    r.sound_level = sound_reg;
    return r;
  endfunction

  // Random idle length: mostly short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  bit idle_gaps = 1'b1;

  // Send one transaction; the expectation is queued when it is accepted
  task automatic send_item(input in_t t);
    int g;
    g = idle_gaps ? gap_len() : 0;
    repeat (g) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    result_queue.push_back(predict_result(t));
    in_valid <= 1'b0;
    // the block stalls for at least this cycle after taking a transaction
    @(posedge clk);
  endtask

  function automatic in_t mk(input logic [1:0] op);
    in_t t;
    t.opcode = op;
    t.load_address = 12'($urandom);
    t.load_byte = 8'($urandom);
    t.keys_down = 16'($urandom);
    t.key_event = ($urandom_range(3) == 0) ? 5'($urandom_range(15)) : 5'($urandom_range(31, 16));
    t.random_byte = 8'($urandom);
    t.row_select = 5'($urandom);
    return t;
  endfunction

  task automatic load_byte(input logic [11:0] a, input logic [7:0] d);
    in_t t;
    t = mk(OP_LOAD);
    t.load_address = a; t.load_byte = d;
    send_item(t);
  endtask

  // Place an instruction at the current program counter and execute it
  task automatic exec_ins(input logic [15:0] ins);
    logic [11:0] at;
    at = pc_reg;
    load_byte(at, ins[15:8]);
    load_byte(at + 12'd1, ins[7:0]);
    send_item(mk(OP_EXEC));
  endtask

  task automatic wait_drain();
    while (result_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls while idle gaps are on, forced hold-off when a test requests it
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off) begin
      hold_cycles <= hold_cycles + 1;
      out_stall <= 1'b1;
    end else
      out_stall <= idle_gaps ? ($urandom_range(99) < 30) : 1'b0;
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        e = result_queue.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pc %h/%h err %b/%b wait %b/%b snd %h/%h row %h/%h",
                     e.program_counter, out_data.program_counter,
                     e.error_flag, out_data.error_flag, e.key_wait, out_data.key_wait,
                     e.sound_level, out_data.sound_level,
                     e.display_row, out_data.display_row);
        end
      end
    end
  end

  // Timeout: generous for the memory clear plus worst-case draws and stalls
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("FAIL chip8_instruction_executor");
      $finish;
    end
  end

  // Directed: every group but 7xkk, every low-byte form, ALU flags, extremes and wraps
  task automatic test_directed();
    in_t t;
    exec_ins(16'h60FF); exec_ins(16'h6101); exec_ins(16'h8014);   // add carry
    exec_ins(16'h6005); exec_ins(16'h8015); exec_ins(16'h8017);   // sub borrow
    exec_ins(16'h6081); exec_ins(16'h8006); exec_ins(16'h800E);
    exec_ins(16'h8121); exec_ins(16'h8122); exec_ins(16'h8123); exec_ins(16'h8100);
    exec_ins(16'h8FF8); exec_ins(16'h0123); exec_ins(16'hE5FF);   // bad forms
    exec_ins(16'h62FF); exec_ins(16'hF218); exec_ins(16'hF215); exec_ins(16'hF307);
    exec_ins(16'hF233); exec_ins(16'hAFFE); exec_ins(16'hF21E); exec_ins(16'hF255);
    exec_ins(16'hFF65); exec_ins(16'hF229); exec_ins(16'hFFFF);
    exec_ins(16'h00E0); exec_ins(16'hA000); exec_ins(16'h603E); exec_ins(16'h611E);
    exec_ins(16'hD01F); exec_ins(16'hD01F);                       // wrap + collision
    exec_ins(16'hC7F0); exec_ins(16'h3700); exec_ins(16'h4700); exec_ins(16'h5010);
    exec_ins(16'h9010); exec_ins(16'hE09E); exec_ins(16'hE0A1);
    exec_ins(16'h2FFE); exec_ins(16'h00EE); exec_ins(16'h00EE);   // stack wrap
    exec_ins(16'hB0FF); exec_ins(16'h1FFF); exec_ins(16'h1000);
    t = mk(OP_EXEC); t.key_event = NO_KEY;
    load_byte(pc_reg, 8'hF4); load_byte(pc_reg + 12'd1, KK_WKEY);
    t.key_event = 5'd31; send_item(t); send_item(t);
    t.key_event = 5'd15; send_item(t);
    for (int r = 0; r < 32; r += 31) begin
      t = mk(OP_ROW); t.row_select = 5'(r); send_item(t);
    end
    send_item(mk(2'd3));
  endtask

  // Random programs: mostly well-formed instructions, some raw noise
  task automatic test_random(input int n);
    logic [15:0] ins;
    in_t t;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send_item(mk(OP_LOAD));
        1: send_item(mk(OP_ROW));
        2: send_item(mk(2'($urandom)));
        default: begin
          ins = 16'($urandom);
          if (ins[15:12] == GRP_MISC && $urandom_range(1)) begin
            case ($urandom_range(5))
              0: ins[7:0] = KK_BCD; 1: ins[7:0] = KK_STR; 2: ins[7:0] = KK_LDR;
              3: ins[7:0] = KK_WKEY; 4: ins[7:0] = KK_SST; default: ins[7:0] = KK_ADDI;
            endcase
          end
          if (ins[15:12] == GRP_DRAW && $urandom_range(3) != 0) ins[3:0] = 4'($urandom_range(3));
          if (ins[15:12] == GRP_KEY && $urandom_range(3) != 0)
            ins[7:0] = $urandom_range(1) ? KK_SKP : KK_SKNP;
          if (ins[15:12] == GRP_SYS && $urandom_range(3) != 0)
            ins[7:0] = $urandom_range(1) ? KK_RET : KK_CLS;
          exec_ins(ins);
        end
      endcase
    end
  endtask

  // Receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(20);
      begin
        wait (hold_cycles >= 600);
        hold_off = 1'b0;
      end
    join
    wait_drain();
  endtask

  task automatic test_no_gaps();
    idle_gaps = 1'b0;
    test_random(60);
    idle_gaps = 1'b1;
  endtask

  initial begin
    clear_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drain();
    test_random(170);
    test_backpressure();
    test_no_gaps();
    test_random(170);
    wait_drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && result_queue.size() == 0)
      $display("PASS chip8_instruction_executor");
    else
      $display("FAIL chip8_instruction_executor");
    $finish;
  end

endmodule

[files.f]
hdl/c8_pkg.sv
hdl/c8_mem.sv
hdl/c8_regs.sv
hdl/c8_frame.sv
hdl/chip8_instruction_executor.sv
tb/sv/tb.sv
